/* src/scbpa_pkg.sv */
`default_nettype none

package scbpa_pkg;

   localparam int FIELD_ADDR_W = 32;
   localparam int REQ_SIZE_W   = 16;
   localparam int POOL_W       = 3;
   localparam int COUNT_W      = 7;
   localparam int IDX_W        = 6;
   localparam int SIZE_W       = 10;
   localparam int SPAN_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;

   localparam logic [31:0] HEAP_BASE_RESET = 32'd536870912;
   localparam logic [31:0] HEAP_END_RESET  = 32'd537067520;

   typedef logic [POOL_W-1:0]   pool_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NOMEM   = 2'd1;
   localparam status_type ST_BELOW   = 2'd2;
   localparam status_type ST_INVALID = 2'd3;

   localparam pool_type POOL_NONE = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_END  = 1'd1;

   // Block size in bytes of each pool; the eighth pool exists only for layout.
   function automatic logic [SIZE_W-1:0] shape_size(input pool_type pool);
      logic [SIZE_W-1:0] s;
      case (pool)
         3'd0: s = 10'd8;
         3'd1: s = 10'd16;
         3'd2: s = 10'd32;
         3'd3: s = 10'd48;
         3'd4: s = 10'd64;
         3'd5: s = 10'd128;
         3'd6: s = 10'd256;
         3'd7: s = 10'd512;
         default: s = 10'd0;
      endcase
      return s;
   endfunction

   function automatic count_type shape_count(input pool_type pool);
      count_type c;
      case (pool)
         3'd0: c = 7'd40;
         3'd1: c = 7'd20;
         3'd2: c = 7'd20;
         3'd3: c = 7'd20;
         3'd4: c = 7'd20;
         3'd5: c = 7'd10;
         3'd6: c = 7'd5;
         3'd7: c = 7'd0;
         default: c = 7'd0;
      endcase
      return c;
   endfunction

   // n blocks of the pool, in bytes
   function automatic logic [SPAN_W-1:0] block_span(input pool_type pool, input count_type n);
      logic [SPAN_W-1:0] w;
      w = SPAN_W'(n);
      case (pool)
         3'd0: return w << 3;
         3'd1: return w << 4;
         3'd2: return w << 5;
         3'd3: return (w << 5) + (w << 4);
         3'd4: return w << 6;
         3'd5: return w << 7;
         3'd6: return w << 8;
         3'd7: return w << 9;
         default: return '0;
      endcase
   endfunction

   // Block index of a byte offset inside the pool's span. 48 goes through
   // a divide by 3 on offset/16, done as a multiply by 171/512.
   function automatic idx_type block_index(input pool_type pool,
                                           input logic [SPAN_W-1:0] off);
      logic [7:0]  x;
      logic [16:0] prod;
      logic [SPAN_W-1:0] q;
      x    = off[11:4];
      prod = 17'(x) * 17'd171;
      case (pool)
         3'd0: q = off >> 3;
         3'd1: q = off >> 4;
         3'd2: q = off >> 5;
         3'd3: q = SPAN_W'(prod[16:9]);
         3'd4: q = off >> 6;
         3'd5: q = off >> 7;
         3'd6: q = off >> 8;
         3'd7: q = off >> 9;
         default: q = '0;
      endcase
      return q[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/size_class_block_pool_allocator.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    kind, request_size, block_address
// rsp       out        rsp_valid/stall    granted_address, pool_used, status
// csr       in         csr_we             csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low and no rebuild runs; each item passes
// the input register, the pool decision with stack read and the address add to rsp_valid.
// Throughput is bound by the single stack memory port pair: one pop or push a cycle.
// After reset and after every heap register write the pools are rebuilt one
// block per cycle, with one further step at each pool boundary, for at most 135
// created blocks; req_stall is high during the rebuild.
// Each stage holds while the stage after it is full and stalled.
module size_class_block_pool_allocator
   import scbpa_pkg::*;
#(
   parameter int POOL_COUNT      = 7,
   parameter int MAX_POOL_BLOCKS = 64,
   parameter int ADDR_BITS       = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_kind,
   input  wire logic [REQ_SIZE_W-1:0]    req_request_size,
   input  wire logic [FIELD_ADDR_W-1:0]  req_block_address,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [FIELD_ADDR_W-1:0]       rsp_granted_address,
   output logic [POOL_W-1:0]             rsp_pool_used,
   output logic [STATUS_W-1:0]           rsp_status,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PIDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int POS_W  = $clog2(MAX_POOL_BLOCKS);
   localparam int DEPTH  = POOL_COUNT * MAX_POOL_BLOCKS;
   localparam int MEM_AW = $clog2(DEPTH);
   localparam logic [POS_W-1:0] POS_MASK = POS_W'(MAX_POOL_BLOCKS - 1);
   localparam logic [PIDX_W-1:0] LAST_POOL = PIDX_W'(POOL_COUNT - 1);
   localparam count_type MAX_BLOCKS = COUNT_W'(MAX_POOL_BLOCKS);

   // configuration and pool layout
   logic [ADDR_BITS-1:0] heap_base_ff, heap_end_ff;
   logic [ADDR_BITS-1:0] start_ff   [POOL_COUNT];
   count_type            created_ff [POOL_COUNT];
   count_type            count_ff   [POOL_COUNT];
   count_type            mark_ff    [POOL_COUNT];

   // rebuild sequencer
   logic                 busy_ff;
   logic [PIDX_W-1:0]    rb_pool_ff;
   count_type            rb_blk_ff;
   logic [ADDR_BITS-1:0] rb_addr_ff;

   logic [SIZE_W-1:0]    rb_size;
   count_type            rb_want;
   logic [ADDR_BITS:0]   rb_sum;
   logic                 rb_grow;

   // stack memory
   idx_type              stack_ff [DEPTH];
   idx_type              pop_data_ff;
   logic                 mem_wr, mem_rd;
   logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
   idx_type              mem_wdata;

   // pipeline
   logic                 a_valid_ff, a_kind_ff;
   logic [REQ_SIZE_W-1:0] a_size_ff;
   logic [ADDR_BITS-1:0] a_addr_ff;

   logic                 b_valid_ff, b_pop_ff, b_init_ff;
   logic [POS_W-1:0]     b_top_ff;
   pool_type             b_pool_ff;
   status_type           b_status_ff;
   logic [ADDR_BITS-1:0] b_start_ff;

   logic                 rsp_valid_ff;
   logic [FIELD_ADDR_W-1:0] rsp_addr_ff;
   pool_type             rsp_pool_ff;
   status_type           rsp_status_ff;

   logic out_ready, b_ready, a_ready, a_fire, b_fire, req_fire;

   // stage A decision
   logic                 al_hit, fr_hit;
   logic [PIDX_W-1:0]    al_pool, fr_pool;
   count_type            al_count, al_top, al_mark;
   logic [POS_W-1:0]     al_pos, fr_pos;
   logic [ADDR_BITS-1:0] fr_offset;
   logic [SPAN_W-1:0]    fr_limit;
   logic                 fr_in_range, fr_full;
   idx_type              fr_idx;
   logic                 do_pop, do_push;
   status_type           a_status;
   pool_type             a_pool;
   logic [ADDR_BITS-1:0] a_start;

   // stage B
   idx_type              b_idx;
   logic [ADDR_BITS-1:0] b_granted;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || (b_ready && !busy_ff);
   assign a_fire    = a_valid_ff && b_ready && !busy_ff;
   assign b_fire    = b_valid_ff && out_ready;
   assign req_stall = !a_ready || busy_ff;
   assign req_fire  = req_valid && !req_stall;

   // rebuild: one block or one pool boundary per cycle
   always_comb begin
      rb_size = shape_size(POOL_W'(rb_pool_ff));
      rb_want = shape_count(POOL_W'(rb_pool_ff));
      if (rb_want > MAX_BLOCKS) begin
         rb_want = MAX_BLOCKS;
      end
      rb_sum  = {1'b0, rb_addr_ff} + (ADDR_BITS + 1)'(rb_size);
      rb_grow = (rb_blk_ff < rb_want) && (rb_sum < {1'b0, heap_end_ff});
   end

   // stage A: pick the pool for the item
   always_comb begin
      al_hit  = 1'b0;
      al_pool = '0;
      for (int p = POOL_COUNT - 1; p >= 0; p--) begin
         if (REQ_SIZE_W'(shape_size(POOL_W'(p))) >= a_size_ff && count_ff[p] != '0) begin
            al_hit  = 1'b1;
            al_pool = PIDX_W'(p);
         end
      end
      fr_hit  = 1'b0;
      fr_pool = '0;
      for (int p = 0; p < POOL_COUNT; p++) begin
         if (a_addr_ff >= start_ff[p]) begin
            fr_hit  = 1'b1;
            fr_pool = PIDX_W'(p);
         end
      end

      al_count = count_ff[al_pool];
      al_top   = al_count - COUNT_W'(1);
      al_mark  = mark_ff[al_pool];
      al_pos   = al_top[POS_W-1:0] & POS_MASK;

      fr_offset   = a_addr_ff - start_ff[fr_pool];
      fr_limit    = block_span(POOL_W'(fr_pool), created_ff[fr_pool]);
      fr_in_range = fr_offset < ADDR_BITS'(fr_limit);
      fr_full     = count_ff[fr_pool] >= created_ff[fr_pool];
      fr_idx      = block_index(POOL_W'(fr_pool), fr_offset[SPAN_W-1:0]);
      fr_pos      = count_ff[fr_pool][POS_W-1:0] & POS_MASK;

      do_pop  = 1'b0;
      do_push = 1'b0;
      a_pool  = POOL_NONE;
      a_start = start_ff[al_pool];
      if (a_kind_ff == KIND_ALLOC) begin
         if (al_hit) begin
            do_pop   = 1'b1;
            a_pool   = POOL_W'(al_pool);
            a_status = ST_OK;
         end else begin
            a_status = ST_NOMEM;
         end
      end else if (!fr_hit) begin
         a_status = ST_BELOW;
      end else if (!fr_in_range || fr_full) begin
         a_status = ST_INVALID;
      end else begin
         do_push  = 1'b1;
         a_pool   = POOL_W'(fr_pool);
         a_status = ST_OK;
      end

      mem_rd    = a_fire && do_pop;
      mem_wr    = a_fire && do_push;
      mem_raddr = MEM_AW'(al_pool) * MEM_AW'(MAX_POOL_BLOCKS) + MEM_AW'(al_pos);
      mem_waddr = MEM_AW'(fr_pool) * MEM_AW'(MAX_POOL_BLOCKS) + MEM_AW'(fr_pos);
      mem_wdata = fr_idx;
   end

   // stage B: entries below the low-water mark were never rewritten
   always_comb begin
      b_idx     = b_init_ff ? IDX_W'(b_top_ff) : pop_data_ff;
      b_granted = b_start_ff + ADDR_BITS'(block_span(b_pool_ff, COUNT_W'(b_idx)));
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         stack_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         pop_data_ff <= stack_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= HEAP_BASE_RESET[ADDR_BITS-1:0];
         heap_end_ff  <= HEAP_END_RESET[ADDR_BITS-1:0];
         busy_ff      <= 1'b1;
         rb_pool_ff   <= '0;
         rb_blk_ff    <= '0;
         rb_addr_ff   <= HEAP_BASE_RESET[ADDR_BITS-1:0];
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < POOL_COUNT; p++) begin
            count_ff[p] <= '0;
            mark_ff[p]  <= '0;
         end
      end else begin
         if (csr_we && (csr_index == CSR_HEAP_BASE || csr_index == CSR_HEAP_END)) begin
            // restart the layout from the (new) heap base
            busy_ff    <= 1'b1;
            rb_pool_ff <= '0;
            rb_blk_ff  <= '0;
            if (csr_index == CSR_HEAP_BASE) begin
               heap_base_ff <= csr_wdata[ADDR_BITS-1:0];
               rb_addr_ff   <= csr_wdata[ADDR_BITS-1:0];
            end else begin
               heap_end_ff <= csr_wdata[ADDR_BITS-1:0];
               rb_addr_ff  <= heap_base_ff;
            end
         end else if (busy_ff) begin
            if (rb_grow) begin
               rb_blk_ff  <= rb_blk_ff + COUNT_W'(1);
               rb_addr_ff <= rb_sum[ADDR_BITS-1:0];
            end else begin
               count_ff[rb_pool_ff] <= rb_blk_ff;
               mark_ff[rb_pool_ff]  <= rb_blk_ff;
               rb_blk_ff            <= '0;
               rb_pool_ff           <= rb_pool_ff + PIDX_W'(1);
               if (rb_pool_ff == LAST_POOL) begin
                  busy_ff <= 1'b0;
               end
            end
         end

         if (a_fire && do_pop) begin
            count_ff[al_pool] <= al_top;
            if (al_top < al_mark) begin
               mark_ff[al_pool] <= al_top;
            end
         end
         if (a_fire && do_push) begin
            count_ff[fr_pool] <= count_ff[fr_pool] + COUNT_W'(1);
         end

         if (req_fire) begin
            a_valid_ff <= 1'b1;
         end else if (a_fire) begin
            a_valid_ff <= 1'b0;
         end
         if (a_fire) begin
            b_valid_ff <= 1'b1;
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // layout and item payload
   always_ff @(posedge clock) begin
      if (busy_ff && rb_blk_ff == '0 && !csr_we) begin
         start_ff[rb_pool_ff] <= rb_addr_ff;
      end
      if (busy_ff && !rb_grow && !csr_we) begin
         created_ff[rb_pool_ff] <= rb_blk_ff;
      end
      if (req_fire) begin
         a_kind_ff <= req_kind;
         a_size_ff <= req_request_size;
         a_addr_ff <= req_block_address[ADDR_BITS-1:0];
      end
      if (a_fire) begin
         b_pop_ff    <= do_pop;
         b_init_ff   <= {1'b0, al_pos} < al_mark;
         b_top_ff    <= al_pos;
         b_pool_ff   <= a_pool;
         b_status_ff <= a_status;
         b_start_ff  <= a_start;
      end
      if (b_fire) begin
         rsp_addr_ff   <= b_pop_ff ? FIELD_ADDR_W'(b_granted) : '0;
         rsp_pool_ff   <= b_pool_ff;
         rsp_status_ff <= b_status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_pool_used       = rsp_pool_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTHESIS
   a_fail_has_no_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_pool_used == POOL_NONE)
      else $error("failed item reports a pool");

   a_only_alloc_grants: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_address == '0)
      else $error("failed item reports an address");

   a_rebuild_blocks_items: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_stall && !a_fire)
      else $error("item processed during pool rebuild");

   a_pool0_bounded: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> count_ff[0] <= created_ff[0] && mark_ff[0] <= count_ff[0])
      else $error("pool 0 free count out of bounds");

   a_single_stack_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd && mem_wr))
      else $error("push and pop in the same cycle");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
   import scbpa_pkg::*;
();

   localparam int MIRROR_POOLS   = 7;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REBUILD_CYCLES = 160;

   typedef struct {
      logic [31:0] granted;
      pool_type    pool;
      status_type  status;
   } pool_reply_type;

   typedef struct {
      logic [31:0] addr;
      int unsigned pool;
   } held_block_type;

   class heap_pool_mirror;
      logic [63:0]    heap_base;
      logic [63:0]    heap_end;
      idx_type        free_idx[MIRROR_POOLS][64];
      int unsigned    free_depth[MIRROR_POOLS];
      int unsigned    made_blocks[MIRROR_POOLS];
      logic [63:0]    pool_base[MIRROR_POOLS];
      pool_reply_type due_replies[$];
      int             mismatches;

      function new();
         heap_base  = 64'(HEAP_BASE_RESET);
         heap_end   = 64'(HEAP_END_RESET);
         mismatches = 0;
         lay_out();
      endfunction

      static function int unsigned block_bytes(int unsigned pool);
         case (pool)
            0: return 8;
            1: return 16;
            2: return 32;
            3: return 48;
            4: return 64;
            5: return 128;
            default: return 256;
         endcase
      endfunction

      static function int unsigned block_quota(int unsigned pool);
         case (pool)
            0: return 40;
            5: return 10;
            6: return 5;
            default: return 20;
         endcase
      endfunction

      // Pools follow one another; a block exists only if it ends strictly below heap_end.
      function void lay_out();
         logic [63:0] cursor;
         int unsigned bytes;
         cursor = heap_base;
         for (int p = 0; p < MIRROR_POOLS; p++) begin
            for (int b = 0; b < 64; b++) free_idx[p][b] = '0;
            pool_base[p]   = {32'd0, cursor[31:0]};
            made_blocks[p] = 0;
            bytes          = block_bytes(p);
            for (int b = 0; b < block_quota(p); b++) begin
               if (cursor + 64'(bytes) >= heap_end) break;
               free_idx[p][b] = idx_type'(b);
               made_blocks[p] = b + 1;
               cursor         = cursor + 64'(bytes);
            end
            free_depth[p] = made_blocks[p];
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
         if (index == CSR_HEAP_BASE) begin
            heap_base = {32'd0, value};
         end else begin
            heap_end = {32'd0, value};
         end
         lay_out();
      endfunction

      function pool_reply_type take_request(logic kind, logic [15:0] size, logic [31:0] addr);
         pool_reply_type r;
         logic [63:0]    off;
         logic [63:0]    idx;
         int             hit;
         int unsigned    top;
         r.granted = '0;
         r.pool    = POOL_NONE;
         if (kind == KIND_ALLOC) begin
            r.status = ST_NOMEM;
            for (int p = 0; p < MIRROR_POOLS; p++) begin
               if (block_bytes(p) >= size && free_depth[p] > 0) begin
                  top           = free_depth[p] - 1;
                  free_depth[p] = top;
                  r.granted     = 32'(pool_base[p] + 64'(free_idx[p][top]) * 64'(block_bytes(p)));
                  r.pool        = pool_type'(p);
                  r.status      = ST_OK;
                  break;
               end
            end
         end else begin
            hit = -1;
            for (int p = MIRROR_POOLS - 1; p >= 0; p--) begin
               if ({32'd0, addr} >= pool_base[p]) begin
                  hit = p;
                  break;
               end
            end
            if (hit < 0) begin
               r.status = ST_BELOW;
            end else begin
               off = {32'd0, addr} - pool_base[hit];
               idx = off / 64'(block_bytes(hit));
               // drop blocks past the pool and pushes onto a full stack
               if (idx >= 64'(made_blocks[hit]) || free_depth[hit] >= made_blocks[hit]) begin
                  r.status = ST_INVALID;
               end else begin
                  free_idx[hit][free_depth[hit]] = idx_type'(idx);
                  free_depth[hit]++;
                  r.pool   = pool_type'(hit);
                  r.status = ST_OK;
               end
            end
         end
         due_replies.push_back(r);
         return r;
      endfunction

      task flag_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task match_response(logic [31:0] granted, pool_type pool, status_type status);
         pool_reply_type want;
         if (due_replies.size() == 0) begin
            flag_mismatch($sformatf("unrequested item: addr %h pool %0d status %0d",
                                    granted, pool, status));
            return;
         end
         want = due_replies.pop_front();
         if (granted !== want.granted)
            flag_mismatch($sformatf("granted_address %h, want %h", granted, want.granted));
         if (pool !== want.pool)
            flag_mismatch($sformatf("pool_used %0d, want %0d", pool, want.pool));
         if (status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_kind = KIND_ALLOC;
   logic [REQ_SIZE_W-1:0]   req_request_size = '0;
   logic [FIELD_ADDR_W-1:0] req_block_address = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [FIELD_ADDR_W-1:0] rsp_granted_address;
   logic [POOL_W-1:0]       rsp_pool_used;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_HEAP_BASE;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   heap_pool_mirror mirror;
   held_block_type  held_blocks[$];
   int              send_gap_pct = 0;
   int              stall_pct = 0;
   int              hold_budget = 0;
   int              hold_spent = 0;

   size_class_block_pool_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_pool_used       (rsp_pool_used),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   // hold off for every cycle granted by the main sequence, else stall at random
   always @(posedge clock) begin
      if (hold_spent < hold_budget) begin
         rsp_stall <= 1'b1;
         hold_spent = hold_spent + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         mirror.match_response(rsp_granted_address, rsp_pool_used, rsp_status);
   end

   task automatic send_item(input logic kind, input logic [15:0] size, input logic [31:0] addr);
      pool_reply_type r;
      held_block_type hb;
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_request_size  <= size;
      req_block_address <= addr;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      r = mirror.take_request(kind, size, addr);
      if (kind == KIND_ALLOC && r.status == ST_OK) begin
         hb.addr = r.granted;
         hb.pool = r.pool;
         held_blocks.push_back(hb);
      end
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
   endtask

   // keep: leave the block on the list so it can be freed twice
   task automatic free_held(input bit keep);
      int             k;
      held_block_type blk;
      logic [31:0]    a;
      k   = $urandom_range(held_blocks.size() - 1);
      blk = held_blocks[k];
      if (!keep) held_blocks.delete(k);
      a = blk.addr;
      if ($urandom_range(3) == 0)
         a = a + $urandom_range(mirror.block_bytes(blk.pool) - 1);
      send_item(KIND_FREE, 16'($urandom), a);
   endtask

   function automatic logic [15:0] pick_size();
      int unsigned edge_bytes;
      case ($urandom_range(9))
         0: return 16'($urandom_range(8));
         1, 2: begin
            edge_bytes = mirror.block_bytes($urandom_range(MIRROR_POOLS - 1));
            return 16'(edge_bytes + $urandom_range(2) - 1);
         end
         3, 4, 5: return 16'($urandom_range(64));
         9: return 16'($urandom_range(257, 65535));
         default: return 16'($urandom_range(256));
      endcase
   endfunction

   task automatic random_item(input int n);
      int          roll;
      int          free_pct;
      logic [31:0] base;
      // alternate between filling the pools and draining them
      free_pct = ((n / 120) % 2 == 1) ? 70 : 35;
      roll     = $urandom_range(99);
      base     = mirror.heap_base[31:0];
      if (roll < free_pct && held_blocks.size() > 0) begin
         free_held(1'b0);
      end else if (roll < 88) begin
         send_item(KIND_ALLOC, pick_size(), $urandom);
      end else begin
         case (roll % 4)
            0: send_item(KIND_FREE, 16'($urandom), $urandom);
            1: send_item(KIND_FREE, 16'($urandom), (base == 0) ? 32'd0 : $urandom_range(base - 1));
            2: send_item(KIND_FREE, 16'($urandom), base + $urandom_range(6143));
            default: begin
               if (held_blocks.size() > 0) free_held(1'b1);
               else send_item(KIND_ALLOC, 16'($urandom), $urandom);
            end
         endcase
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.due_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // the pause covers the pool rebuild that this write started
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.write_reg(index, value);
      repeat (REBUILD_CYCLES) @(posedge clock);
   endtask

   task automatic directed_items();
      int unsigned    probe_sizes[13] = '{8, 9, 16, 17, 32, 33, 48, 49, 64, 65, 128, 129, 256};
      held_block_type blk;
      // zero-byte request lands in the smallest pool
      send_item(KIND_ALLOC, 16'd0, 32'hFFFF_FFFF);
      foreach (probe_sizes[i]) send_item(KIND_ALLOC, 16'(probe_sizes[i]), 32'd0);
      send_item(KIND_ALLOC, 16'd257, 32'd0);
      send_item(KIND_ALLOC, 16'hFFFF, 32'd0);
      send_item(KIND_FREE, 16'hFFFF, 32'd0);
      // unaligned free, then the same block again while the stack still has room
      blk = held_blocks[0];
      held_blocks.delete(0);
      repeat (2) send_item(KIND_FREE, 16'd0, blk.addr + 32'd5);
      // pool 0 is full again: a further free is a double free
      send_item(KIND_FREE, 16'd0, HEAP_BASE_RESET);
      send_item(KIND_FREE, 16'd0, 32'hFFFF_FFFF);
   endtask

   task automatic run_phase(input logic [31:0] base, input logic [31:0] top, input bit rewrite,
                            input int items, input int mode, input int hold);
      if (rewrite) begin
         settle();
         write_reg(CSR_HEAP_BASE, base);
         write_reg(CSR_HEAP_END, top);
         held_blocks.delete();
      end
      case (mode)
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 58; stall_pct = 0;  end
         2: begin send_gap_pct = 0;  stall_pct = 58; end
         default: begin send_gap_pct = 9; stall_pct = 9; end
      endcase
      hold_budget = hold_budget + hold;
      for (int n = 0; n < items; n++) random_item(n);
   endtask

   initial begin
      logic [31:0] rbase;
      logic [32:0] rsum;
      mirror = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      directed_items();
      run_phase(HEAP_BASE_RESET, HEAP_END_RESET, 1'b0, 230, 0, 0);
      run_phase(32'h0000_1000, 32'h0000_1BB8, 1'b1, 230, 1, 0);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 250, 2, 400);
      run_phase(32'hFFFF_F800, 32'hFFFF_FFFF, 1'b1, 200, 3, 0);
      run_phase(32'h8000_0000, 32'h8000_0000, 1'b1, 100, 0, 0);
      run_phase(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 80, 1, 0);
      rbase = $urandom;
      rsum  = {1'b0, rbase} + 33'($urandom_range(7000));
      run_phase(rbase, rsum[32] ? 32'hFFFF_FFFF : rsum[31:0], 1'b1, 200, 2, 0);
      // the last block of the largest pool would end exactly at heap_end
      run_phase(32'h0000_0040, 32'h0000_0040 + 32'd6080, 1'b1, 160, 3, 0);
      run_phase(HEAP_BASE_RESET, HEAP_END_RESET, 1'b1, 200, 0, 0);
      settle();
      if (mirror.mismatches == 0 && mirror.due_replies.size() == 0) begin
         $display("size_class_block_pool_allocator test passed");
      end else begin
         $display("size_class_block_pool_allocator test failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("size_class_block_pool_allocator test failed");
      $finish;
   end

endmodule
